[rtl/dpc_pkg.sv]
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants of the differential pump controller
// Payload structs, register indexes, reset values and fixed thresholds.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int unsigned TempW  = 12;
  localparam int unsigned TimerW = 16;
  localparam int unsigned HystW  = 8;
  localparam int unsigned TrimW  = 7;
  localparam int unsigned HistW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // fixed thresholds in tenths of a degree
  localparam logic [TempW-1:0] T1MinTemp  = TempW'(350);
  localparam logic [TempW-1:0] DiffMargin = TempW'(50);
  localparam logic [TempW-1:0] T3MaxTemp  = TempW'(420);
  localparam logic [TempW-1:0] T2MaxTemp  = TempW'(500);
  localparam logic [TempW-1:0] T4MinTemp  = TempW'(350);

  localparam logic [HistW-1:0] HistReset  = '1;
  localparam logic [HistW-1:0] PressPat   = 3'b100;

  localparam logic [TimerW-1:0] BootHoldReset = TimerW'(260);
  localparam logic [TimerW-1:0] MinOnReset    = TimerW'(3120);
  localparam logic [TimerW-1:0] MaxOnReset    = TimerW'(23400);
  localparam logic [TimerW-1:0] OffHoldReset  = TimerW'(7800);
  localparam logic [TempW-1:0]  ThermoHiReset = TempW'(800);
  localparam logic [TempW-1:0]  ThermoLoReset = TempW'(700);
  localparam logic [HystW-1:0]  HystReset     = HystW'(20);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOOT_HOLD = 3'd0,
    CFG_MIN_ON    = 3'd1,
    CFG_MAX_ON    = 3'd2,
    CFG_OFF_HOLD  = 3'd3,
    CFG_THERMO_HI = 3'd4,
    CFG_THERMO_LO = 3'd5,
    CFG_HYST      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TempW-1:0] temp_one;
    logic [TempW-1:0] temp_two;
    logic [TempW-1:0] temp_three;
    logic [TempW-1:0] temp_four;
    logic [TrimW-1:0] trim_offset;
    logic             button_level;
    logic             thermostat_mode;
  } in_t;

  typedef struct packed {
    logic              pump_on;
    logic              low_temp_flag;
    logic [TimerW-1:0] hold_left;
  } out_t;

  typedef struct packed {
    logic [TimerW-1:0] min_on;
    logic [TimerW-1:0] max_on;
    logic [TimerW-1:0] off_hold;
    logic [TempW-1:0]  thermo_hi;
    logic [TempW-1:0]  thermo_lo;
    logic [HystW-1:0]  hyst;
  } cfg_t;

  typedef struct packed {
    logic              pump;
    logic              low_flag;
    logic [TimerW-1:0] hold;
    logic [TimerW-1:0] run;
    logic [HistW-1:0]  hist;
  } state_t;

endpackage

[rtl/dpc_step.sv]
// ----------------------------------------------------------------------------
// dpc_step: next-state logic for one control tick
// Thermostat hysteresis rules and differential timer, block, stop and start
// rules, evaluated in a single combinational pass.
// ----------------------------------------------------------------------------
module dpc_step (
  input  dpc_pkg::in_t    item_i,
  input  dpc_pkg::cfg_t   cfg_i,
  input  dpc_pkg::state_t state_i,
  output dpc_pkg::state_t state_o
);

  logic [dpc_pkg::TempW:0]    hi_thr;
  logic [dpc_pkg::TempW:0]    lo_val;
  logic [dpc_pkg::TempW:0]    t1_margin;
  logic [dpc_pkg::TempW:0]    t3_trim;
  logic [dpc_pkg::TempW:0]    t2_trim;
  logic [dpc_pkg::TimerW-1:0] hold_dec;
  logic [dpc_pkg::TimerW-1:0] run_dec;
  logic [dpc_pkg::HistW-1:0]  hist_n;
  logic                       blocked;
  logic                       pressed;

  assign hi_thr    = {1'b0, cfg_i.thermo_hi} +
                     (state_i.pump ? (dpc_pkg::TempW+1)'(cfg_i.hyst) : '0);
  assign lo_val    = {1'b0, item_i.temp_one} +
                     (state_i.low_flag ? (dpc_pkg::TempW+1)'(cfg_i.hyst) : '0);
  assign t1_margin = {1'b0, item_i.temp_one} + {1'b0, dpc_pkg::DiffMargin};
  assign t3_trim   = {1'b0, item_i.temp_three} + (dpc_pkg::TempW+1)'(item_i.trim_offset);
  assign t2_trim   = {1'b0, item_i.temp_two} + (dpc_pkg::TempW+1)'(item_i.trim_offset);

  assign hold_dec = (state_i.hold != '0) ? state_i.hold - 1'b1 : state_i.hold;
  assign run_dec  = (state_i.run != '0) ? state_i.run - 1'b1 : state_i.run;
  assign hist_n   = {state_i.hist[dpc_pkg::HistW-2:0], item_i.button_level};
  assign pressed  = (hist_n == dpc_pkg::PressPat);

  assign blocked = (item_i.temp_one < dpc_pkg::T1MinTemp) ||
                   ({1'b0, item_i.temp_two} > t1_margin) ||
                   (item_i.temp_three > dpc_pkg::T3MaxTemp) ||
                   (state_i.pump && (run_dec == '0));

  always_comb begin
    state_o = state_i;
    if (item_i.thermostat_mode) begin
      state_o.pump     = ({1'b0, item_i.temp_one} > hi_thr);
      state_o.low_flag = (lo_val < {1'b0, cfg_i.thermo_lo});
    end else begin
      state_o.hold = hold_dec;
      state_o.run  = run_dec;
      if (blocked) begin
        state_o.pump = 1'b0;
        state_o.hold = cfg_i.off_hold;
      end else begin
        state_o.hist = hist_n;
        if (state_i.pump) begin
          if (pressed || ((hold_dec == '0) && ({1'b0, item_i.temp_two} < t3_trim))) begin
            state_o.pump = 1'b0;
            state_o.hold = cfg_i.off_hold;
          end
        end else if (pressed || ((hold_dec == '0) &&
                                 (item_i.temp_two < dpc_pkg::T2MaxTemp) &&
                                 (item_i.temp_four > dpc_pkg::T4MinTemp) &&
                                 ({1'b0, item_i.temp_one} > t2_trim))) begin
          state_o.pump = 1'b1;
          state_o.hold = cfg_i.min_on;
          state_o.run  = cfg_i.max_on;
        end
      end
    end
  end

endmodule

[rtl/differential_pump_controller_core.sv]
// ----------------------------------------------------------------------------
// differential_pump_controller_core: pump controller top level
// A result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one item per cycle while the skid register is free; the state update is one combinational pass.
// An output register plus a skid register decouple the two channels.
// Reset: pump off, low flag clear, hold timer 260, run timer 0, button
// history all ones, configuration registers at their defaults.
// ----------------------------------------------------------------------------
module differential_pump_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dpc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dpc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dpc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  dpc_pkg::cfg_t   cfg_q;
  dpc_pkg::state_t state_q, state_d;
  dpc_pkg::out_t   out_q, skid_q, res_d;
  logic            out_valid_q, skid_valid_q;
  logic            in_xfer, out_xfer;

  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_xfer    = out_valid_q && !out_stall_i;

  // configuration; the boot hold value is a fixed reset value, and writes to its index are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_on    <= dpc_pkg::MinOnReset;
      cfg_q.max_on    <= dpc_pkg::MaxOnReset;
      cfg_q.off_hold  <= dpc_pkg::OffHoldReset;
      cfg_q.thermo_hi <= dpc_pkg::ThermoHiReset;
      cfg_q.thermo_lo <= dpc_pkg::ThermoLoReset;
      cfg_q.hyst      <= dpc_pkg::HystReset;
    end else if (cfg_we_i) begin
      case (dpc_pkg::cfg_idx_e'(cfg_idx_i))
        dpc_pkg::CFG_MIN_ON:    cfg_q.min_on    <= cfg_wdata_i;
        dpc_pkg::CFG_MAX_ON:    cfg_q.max_on    <= cfg_wdata_i;
        dpc_pkg::CFG_OFF_HOLD:  cfg_q.off_hold  <= cfg_wdata_i;
        dpc_pkg::CFG_THERMO_HI: cfg_q.thermo_hi <= cfg_wdata_i[dpc_pkg::TempW-1:0];
        dpc_pkg::CFG_THERMO_LO: cfg_q.thermo_lo <= cfg_wdata_i[dpc_pkg::TempW-1:0];
        dpc_pkg::CFG_HYST:      cfg_q.hyst      <= cfg_wdata_i[dpc_pkg::HystW-1:0];
        default: ;
      endcase
    end
  end

  dpc_step u_step (
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  assign res_d.pump_on       = state_d.pump;
  assign res_d.low_temp_flag = state_d.low_flag;
  assign res_d.hold_left     = state_d.hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pump     <= 1'b0;
      state_q.low_flag <= 1'b0;
      state_q.hold     <= dpc_pkg::BootHoldReset;
      state_q.run      <= '0;
      state_q.hist     <= dpc_pkg::HistReset;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_xfer) begin
        out_valid_q  <= in_xfer || skid_valid_q;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end
    if (in_xfer && out_valid_q && !out_xfer) begin
      skid_q <= res_d;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

  a_thermo_timers_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.thermostat_mode) |=>
      ($stable(state_q.run) && $stable(state_q.hold) && $stable(state_q.hist)))
    else $error("timers moved in thermostat mode");

  a_diff_flag_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !in_data_i.thermostat_mode) |=> $stable(state_q.low_flag))
    else $error("low flag changed in differential mode");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

[tb/tb_differential_pump_controller_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_differential_pump_controller_core: self-checking bench of the pump core
// Feeds control ticks through the valid/stall input channel, predicts every
// status word with a cycle-free model of the controller and checks it field
// by field at the output channel. Both sides idle in random bursts. The run
// sweeps several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_differential_pump_controller_core;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    dpc_pkg::in_t data;
    bit           drain;
  } tick_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dpc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dpc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [dpc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [dpc_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // controller model state and register copy
  dpc_pkg::state_t ctl;
  dpc_pkg::cfg_t cfg;

  tick_req_t pending[$];
  tick_req_t nxt_tick;
  dpc_pkg::out_t status_due[$];
  dpc_pkg::out_t want;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned holdoff_left = 0;
  int unsigned results = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit send;
  logic quiet = 1'b0;
  logic btn_level = 1'b1;
  int unsigned btn_left = 0;

  always #2 clk_i = ~clk_i;

  differential_pump_controller_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  function automatic dpc_pkg::out_t advance_controller(dpc_pkg::in_t tick);
    int t1, t2, t3, t4, trim, hi, lo;
    bit running, pressed;
    dpc_pkg::out_t r;
    t1 = int'(tick.temp_one);
    t2 = int'(tick.temp_two);
    t3 = int'(tick.temp_three);
    t4 = int'(tick.temp_four);
    trim = int'(tick.trim_offset);
    if (tick.thermostat_mode) begin
      hi = t1;
      lo = t1;
      if (ctl.pump) hi = hi - int'(cfg.hyst);
      ctl.pump = (hi > int'(cfg.thermo_hi));
      if (ctl.low_flag) lo = lo + int'(cfg.hyst);
      ctl.low_flag = (lo < int'(cfg.thermo_lo));
    end else begin
      running = ctl.pump;
      if (ctl.hold != 0) ctl.hold = ctl.hold - 1'b1;
      if (ctl.run != 0) ctl.run = ctl.run - 1'b1;
      if (t1 < int'(dpc_pkg::T1MinTemp) || t2 > t1 + int'(dpc_pkg::DiffMargin) ||
          t3 > int'(dpc_pkg::T3MaxTemp) || (running && ctl.run == 0)) begin
        ctl.pump = 1'b0;
        ctl.hold = cfg.off_hold;
      end else begin
        ctl.hist = {ctl.hist[dpc_pkg::HistW-2:0], tick.button_level};
        pressed = (ctl.hist == dpc_pkg::PressPat);
        if (running) begin
          if (pressed || (ctl.hold == 0 && t2 < t3 + trim)) begin
            ctl.pump = 1'b0;
            ctl.hold = cfg.off_hold;
          end
        end else if (pressed || (ctl.hold == 0 && t2 < int'(dpc_pkg::T2MaxTemp) &&
                                 t4 > int'(dpc_pkg::T4MinTemp) && t1 > t2 + trim)) begin
          ctl.pump = 1'b1;
          ctl.hold = cfg.min_on;
          ctl.run = cfg.max_on;
        end
      end
    end
    r.pump_on = ctl.pump;
    r.low_temp_flag = ctl.low_flag;
    r.hold_left = ctl.hold;
    return r;
  endfunction

  function automatic logic [dpc_pkg::TempW-1:0] clamp_temp(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return dpc_pkg::TempW'(v);
  endfunction

  function automatic dpc_pkg::in_t mk_tick(int t1, int t2, int t3, int t4, int trim,
                                           bit btn, bit thermo);
    dpc_pkg::in_t it;
    it.temp_one = clamp_temp(t1);
    it.temp_two = clamp_temp(t2);
    it.temp_three = clamp_temp(t3);
    it.temp_four = clamp_temp(t4);
    it.trim_offset = dpc_pkg::TrimW'(trim);
    it.button_level = btn;
    it.thermostat_mode = thermo;
    return it;
  endfunction

  function automatic dpc_pkg::in_t random_tick();
    int sel, t1, t2, t3, t4, trim, base, span;
    sel = $urandom_range(0, 99);
    if (btn_left == 0) begin
      btn_level = $urandom_range(0, 1);
      btn_left = $urandom_range(1, 5);
    end
    btn_left--;
    trim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : 10 * $urandom_range(0, 11);
    if (sel < 8) begin
      return mk_tick($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 1));
    end
    if (sel < 25) begin
      base = $urandom_range(0, 1) ? int'(cfg.thermo_hi) : int'(cfg.thermo_lo);
      span = int'(cfg.hyst) + 30;
      t1 = base + $urandom_range(0, 2 * span) - span;
      return mk_tick(t1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), trim, btn_level, 1'b1);
    end
    t1 = (sel < 28) ? $urandom_range(0, 349) : $urandom_range(350, 900);
    t2 = (sel < 31) ? t1 + 51 + $urandom_range(0, 300) : t1 + 50 - $urandom_range(0, 200);
    t3 = (sel < 34) ? $urandom_range(421, 4095) : $urandom_range(0, 420);
    t4 = $urandom_range(250, 600);
    return mk_tick(t1, t2, t3, t4, trim, btn_level, 1'b0);
  endfunction

  task automatic write_reg(dpc_pkg::cfg_idx_e idx, logic [dpc_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      dpc_pkg::CFG_MIN_ON:    cfg.min_on = val;
      dpc_pkg::CFG_MAX_ON:    cfg.max_on = val;
      dpc_pkg::CFG_OFF_HOLD:  cfg.off_hold = val;
      dpc_pkg::CFG_THERMO_HI: cfg.thermo_hi = val[dpc_pkg::TempW-1:0];
      dpc_pkg::CFG_THERMO_LO: cfg.thermo_lo = val[dpc_pkg::TempW-1:0];
      dpc_pkg::CFG_HYST:      cfg.hyst = val[dpc_pkg::HystW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || status_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic push_tick(dpc_pkg::in_t it, bit drain);
    tick_req_t req;
    req.data = it;
    req.drain = drain;
    pending.push_back(req);
  endtask

  task automatic run_random(int n, int drain_at);
    for (int i = 0; i < n; i++) push_tick(random_tick(), i == drain_at);
    settle();
  endtask

  task automatic random_setting();
    write_reg(dpc_pkg::CFG_MIN_ON, $urandom_range(0, 20));
    write_reg(dpc_pkg::CFG_MAX_ON, $urandom_range(0, 80));
    write_reg(dpc_pkg::CFG_OFF_HOLD, $urandom_range(0, 20));
    write_reg(dpc_pkg::CFG_THERMO_HI, $urandom_range(300, 900));
    write_reg(dpc_pkg::CFG_THERMO_LO, $urandom_range(300, 900));
    write_reg(dpc_pkg::CFG_HYST, $urandom_range(0, 60));
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) status_due.push_back(advance_controller(in_data));
      if (!in_valid || !in_stall) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0 && !(pending[0].drain && status_due.size() != 0)) begin
          if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(0, 10);
          else send = 1'b1;
        end
        if (send) begin
          nxt_tick = pending.pop_front();
          in_data <= nxt_tick.data;
        end
        in_valid <= send;
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results++;
        if (results == 700) holdoff_left = 200;
        if (status_due.size() == 0) begin
          $error("result transfer with no status pending: %p", out_data);
          errors++;
        end else begin
          want = status_due.pop_front();
          if (out_data.pump_on !== want.pump_on) begin
            $error("pump_on: expected %0d, got %0d", want.pump_on, out_data.pump_on);
            errors++;
          end
          if (out_data.low_temp_flag !== want.low_temp_flag) begin
            $error("low_temp_flag: expected %0d, got %0d", want.low_temp_flag,
                   out_data.low_temp_flag);
            errors++;
          end
          if (out_data.hold_left !== want.hold_left) begin
            $error("hold_left: expected %0d, got %0d", want.hold_left, out_data.hold_left);
            errors++;
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[differential_pump_controller_core] ERROR");
      $finish;
    end
  end

  initial begin
    ctl = '{pump: 1'b0, low_flag: 1'b0, hold: dpc_pkg::BootHoldReset, run: '0,
            hist: dpc_pkg::HistReset};
    cfg = '{min_on: dpc_pkg::MinOnReset, max_on: dpc_pkg::MaxOnReset,
            off_hold: dpc_pkg::OffHoldReset, thermo_hi: dpc_pkg::ThermoHiReset,
            thermo_lo: dpc_pkg::ThermoLoReset, hyst: dpc_pkg::HystReset};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // thermostat thresholds, hysteresis and a negative t1 - hyst
    push_tick(mk_tick(4095, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(815, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(4095, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(5, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(690, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(0, 4095, 4095, 4095, 127, 0, 1), 0);
    // block conditions
    push_tick(mk_tick(349, 0, 0, 4095, 0, 1, 0), 0);
    push_tick(mk_tick(600, 651, 0, 0, 0, 1, 0), 0);
    push_tick(mk_tick(600, 400, 421, 0, 0, 1, 0), 0);
    push_tick(mk_tick(0, 0, 0, 0, 0, 0, 0), 0);
    // press to start, press to stop
    push_tick(mk_tick(600, 400, 300, 400, 127, 1, 0), 0);
    push_tick(mk_tick(600, 400, 300, 400, 127, 0, 0), 0);
    push_tick(mk_tick(600, 400, 300, 400, 127, 0, 0), 0);
    push_tick(mk_tick(600, 400, 300, 400, 0, 1, 0), 0);
    push_tick(mk_tick(600, 400, 300, 400, 0, 0, 0), 0);
    push_tick(mk_tick(600, 400, 300, 400, 0, 0, 0), 0);
    push_tick(mk_tick(4095, 4095, 420, 4095, 127, 1, 0), 0);
    push_tick(mk_tick(350, 400, 0, 0, 110, 1, 0), 0);
    // mode switches keep the history; thermostat ticks decide the pump anew
    push_tick(mk_tick(600, 0, 0, 0, 0, 0, 1), 0);
    push_tick(mk_tick(600, 400, 300, 400, 0, 0, 0), 0);
    push_tick(mk_tick(600, 400, 300, 400, 0, 0, 0), 0);
    push_tick(mk_tick(900, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(815, 0, 0, 0, 0, 1, 1), 0);
    push_tick(mk_tick(600, 400, 300, 400, 0, 1, 0), 0);
    settle();

    write_reg(dpc_pkg::CFG_BOOT_HOLD, 16'd0);
    write_reg(dpc_pkg::CFG_MIN_ON, 16'd5);
    write_reg(dpc_pkg::CFG_MAX_ON, 16'd40);
    write_reg(dpc_pkg::CFG_OFF_HOLD, 16'd8);
    write_reg(dpc_pkg::CFG_THERMO_HI, 16'd600);
    write_reg(dpc_pkg::CFG_THERMO_LO, 16'd500);
    write_reg(dpc_pkg::CFG_HYST, 16'd0);
    run_random(300, -1);

    write_reg(dpc_pkg::CFG_MIN_ON, 16'd0);
    write_reg(dpc_pkg::CFG_MAX_ON, 16'd0);
    write_reg(dpc_pkg::CFG_OFF_HOLD, 16'd0);
    write_reg(dpc_pkg::CFG_THERMO_HI, 16'd0);
    write_reg(dpc_pkg::CFG_THERMO_LO, 16'hFFFF);
    write_reg(dpc_pkg::CFG_HYST, 16'hFFFF);
    run_random(150, -1);

    write_reg(dpc_pkg::CFG_BOOT_HOLD, 16'hFFFF);
    write_reg(dpc_pkg::CFG_MIN_ON, 16'hFFFF);
    write_reg(dpc_pkg::CFG_MAX_ON, 16'hFFFF);
    write_reg(dpc_pkg::CFG_OFF_HOLD, 16'hFFFF);
    write_reg(dpc_pkg::CFG_THERMO_HI, 16'd4095);
    write_reg(dpc_pkg::CFG_THERMO_LO, 16'd0);
    write_reg(dpc_pkg::CFG_HYST, 16'd255);
    run_random(100, -1);

    random_setting();
    run_random(400, 300);

    // last stretch without idling on either side
    random_setting();
    quiet <= 1'b1;
    run_random(200, -1);

    if (errors == 0) begin
      $display("[differential_pump_controller_core] OK");
    end else begin
      $display("[differential_pump_controller_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dpc_pkg.sv
rtl/dpc_step.sv
rtl/differential_pump_controller_core.sv
tb/tb_differential_pump_controller_core.sv
